@@ sv/xet_pkg.sv @@
// Shared types, constants and helpers for the XML event tokenizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package xet_pkg;

  localparam int PATH_BYTES = 256;
  localparam int ATTR_LIMIT = 64;
  localparam int PATH_AW    = $clog2(PATH_BYTES);
  localparam int FILL_W     = $clog2(PATH_BYTES + 1);
  localparam int ATTR_W     = $clog2(ATTR_LIMIT + 1);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] EV_OPEN  = 2'd0;
  localparam logic [1:0] EV_CLOSE = 2'd1;
  localparam logic [1:0] EV_ATTR  = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  localparam logic [2:0] ERR_EMPTY      = 3'd0;
  localparam logic [2:0] ERR_BAD_ATTR   = 3'd1;
  localparam logic [2:0] ERR_PATH       = 3'd2;
  localparam logic [2:0] ERR_ATTR_LIMIT = 3'd3;
  localparam logic [2:0] ERR_UNFINISHED = 3'd4;

  typedef enum logic [12:0] {
    P_OUT       = 13'b0000000000001,
    P_TAG       = 13'b0000000000010,
    P_SKIP      = 13'b0000000000100,
    P_CLOSE     = 13'b0000000001000,
    P_NAME      = 13'b0000000010000,
    P_NAME_SL   = 13'b0000000100000,
    P_GAP       = 13'b0000001000000,
    P_GAP_SL    = 13'b0000010000000,
    P_KEY       = 13'b0000100000000,
    P_AFTER_KEY = 13'b0001000000000,
    P_VALWAIT   = 13'b0010000000000,
    P_VALUE     = 13'b0100000000000,
    P_ERR       = 13'b1000000000000
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_PUSH2   = 4'b0010,
    S_POP_RD  = 4'b0100,
    S_POP_CHK = 4'b1000
  } seq_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] name_offset;
    logic [8:0]  name_length;
    logic [31:0] text_offset;
    logic [31:0] text_length;
    logic [8:0]  path_length;
    logic [6:0]  attribute_count;
    logic [2:0]  error_code;
    logic        last_in_run;
  } ev_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
  endfunction

  function automatic logic [8:0] sat_inc9(input logic [8:0] v);
    return (v >= 9'd256) ? 9'd256 : v + 9'd1;
  endfunction

  function automatic logic [8:0] len9(input logic [FILL_W-1:0] v);
    return (int'(v) > 256) ? 9'd256 : 9'(v);
  endfunction

endpackage
`default_nettype wire

@@ sv/xet_in_if.sv @@
// Input channel: one document byte per item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface xet_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface
`default_nettype wire

@@ sv/xet_ev_if.sv @@
// Output channel: one parse event per item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface xet_ev_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [31:0] name_offset;
  logic [8:0]  name_length;
  logic [31:0] text_offset;
  logic [31:0] text_length;
  logic [8:0]  path_length;
  logic [6:0]  attribute_count;
  logic [2:0]  error_code;
  logic        last_in_run;
  modport source (output valid, event_kind, name_offset, name_length, text_offset,
                  text_length, path_length, attribute_count, error_code, last_in_run,
                  input ready);
  modport sink   (input valid, event_kind, name_offset, name_length, text_offset,
                  text_length, path_length, attribute_count, error_code, last_in_run,
                  output ready);
endinterface
`default_nettype wire

@@ sv/xet_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module xet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/xml_event_tokenizer.sv @@
// Top level of the streaming XML event tokenizer.
// Uses xet_pkg, xet_in_if, xet_ev_if and xet_ram.
`timescale 1ns / 1ps
`default_nettype none
// Streaming XML tokenizer. Takes one document byte per item and emits open,
// close, attribute and error events; the slash-joined element path lives in
// a 256-byte path store (one synchronous RAM, one write and one read port).
// Flow per byte: a byte is taken only once all events of the previous byte
// have left and the path sequencer is idle; the two waits overlap, so the
// longer one sets the gap. Plain text and attribute bytes never start the
// sequencer. Each event waits for a ready receiver (at most two per byte).
// A nested open uses the sequencer for the second path byte ('/' and the
// first name byte both go into the store). An element close walks the path
// store back with a read and a check state per byte, the '/' included,
// plus one more read state when the walk empties the path (read latency of
// the path store); the close event drains during the walk. After an error all
// bytes up to end_of_text are swallowed; the end_of_text byte returns every
// counter to zero, so the next document starts at offset 0. The path store
// needs no clearing: only entries below the fill count are ever read.
module xml_event_tokenizer
  import xet_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  xet_in_if.sink   text,
  xet_ev_if.source events
);

  // parser state
  logic [31:0]       pos, pos_next;
  phase_t            phase, phase_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [31:0]       cbeg, cbeg_next;
  logic              cseen, cseen_next;
  logic [31:0]       tok, tok_next;
  logic [31:0]       key_at, key_at_next;
  logic [8:0]        key_len, key_len_next;
  logic [7:0]        quote, quote_next;
  logic [ATTR_W-1:0] attrs, attrs_next;
  logic              pend, pend_next;
  logic [31:0]       name_at, name_at_next;
  logic [FILL_W-1:0] name_len, name_len_next;

  // sequencer for second push and path walk-back
  seq_t              state, state_next;
  logic [PATH_AW-1:0] p2_addr, p2_addr_next;
  logic [7:0]        p2_byte, p2_byte_next;

  // event buffer
  ev_t               ev0, ev0_next, ev1, ev1_next;
  logic [1:0]        cnt, cnt_next;

  // path store port
  logic               wr_en;
  logic [PATH_AW-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic [7:0]         rd_data;

  logic accept;

  assign text.ready = (state == S_IDLE) && (cnt == 2'd0);
  assign accept     = text.valid && text.ready;

  xet_ram #(.WIDTH(8), .DEPTH(PATH_BYTES)) u_path (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (PATH_AW'(fill - FILL_W'(1))),
    .rdata (rd_data)
  );

  always_comb begin
    logic [7:0]        c;
    logic              sp;
    logic [FILL_W-1:0] f;
    logic              p1, p2, do_pop;
    logic [7:0]        p1_byte;
    logic              e_open, e_close, e_close_txt, e_attr, e_err, e_err4;
    logic [2:0]        err_code;
    logic [FILL_W-1:0] ev_fill, err_fill;
    logic              sc;
    ev_t               q [2];
    ev_t               tmp;
    logic [1:0]        n;

    pos_next = pos; phase_next = phase; fill_next = fill; cbeg_next = cbeg;
    cseen_next = cseen; tok_next = tok; key_at_next = key_at;
    key_len_next = key_len; quote_next = quote; attrs_next = attrs;
    pend_next = pend; name_at_next = name_at; name_len_next = name_len;
    state_next = state; p2_addr_next = p2_addr; p2_byte_next = p2_byte;
    ev0_next = ev0; ev1_next = ev1; cnt_next = cnt;
    wr_en = 1'b0; wr_addr = p2_addr; wr_data = p2_byte;

    c = text.text_byte; sp = is_space(c); f = fill;
    p1 = 1'b0; p2 = 1'b0; do_pop = 1'b0; p1_byte = c;
    e_open = 1'b0; e_close = 1'b0; e_close_txt = 1'b0; e_attr = 1'b0;
    e_err = 1'b0; e_err4 = 1'b0; err_code = ERR_EMPTY;
    ev_fill = fill; err_fill = fill; sc = 1'b0;
    q[0] = '0; q[1] = '0; tmp = '0; n = 2'd0;

    // drain
    if (events.valid && events.ready) begin
      ev0_next = ev1;
      cnt_next = cnt - 2'd1;
    end

    case (state)
      S_PUSH2: begin
        wr_en      = 1'b1;
        state_next = S_IDLE;
      end
      S_POP_RD: begin
        state_next = (fill == '0) ? S_IDLE : S_POP_CHK;
      end
      S_POP_CHK: begin
        fill_next  = fill - FILL_W'(1);
        state_next = (rd_data == CH_SLASH) ? S_IDLE : S_POP_RD;
      end
      default: ;
    endcase

    if (accept) begin
      case (phase)
        P_OUT: begin
          if (c == CH_LT) begin
            tok_next = pos; phase_next = P_TAG;
          end else if (!cseen && !sp) begin
            cbeg_next = pos; cseen_next = 1'b1;
          end
        end
        P_TAG: begin
          if (!sp) begin
            if (c == CH_GT) begin
              e_err = 1'b1; err_code = ERR_EMPTY; err_fill = f; phase_next = P_ERR;
            end else if (c == CH_SLASH) begin
              phase_next = P_CLOSE;
            end else if (c == CH_QUEST) begin
              phase_next = P_SKIP;
            end else begin
              attrs_next = '0; pend_next = 1'b0;
              if (int'(f) >= PATH_BYTES) begin
                e_err = 1'b1; err_code = ERR_PATH; err_fill = f; phase_next = P_ERR;
              end else if (f != '0) begin
                p1 = 1'b1; p1_byte = CH_SLASH; f = f + FILL_W'(1);
                if (int'(f) >= PATH_BYTES) begin
                  e_err = 1'b1; err_code = ERR_PATH; err_fill = f; phase_next = P_ERR;
                end else begin
                  p2 = 1'b1; f = f + FILL_W'(1);
                  name_at_next = pos; name_len_next = FILL_W'(1); phase_next = P_NAME;
                end
              end else begin
                p1 = 1'b1; f = f + FILL_W'(1);
                name_at_next = pos; name_len_next = FILL_W'(1); phase_next = P_NAME;
              end
            end
          end
        end
        P_SKIP: begin
          if (c == CH_GT) begin
            phase_next = P_OUT; cseen_next = 1'b0; cbeg_next = '0; pend_next = 1'b0;
          end
        end
        P_CLOSE: begin
          if (c == CH_GT) begin
            e_close = 1'b1; e_close_txt = cseen; ev_fill = f; do_pop = 1'b1;
            phase_next = P_OUT; cseen_next = 1'b0; cbeg_next = '0; pend_next = 1'b0;
          end
        end
        P_NAME: begin
          if (pend) begin
            pend_next = 1'b0;
            if (c == CH_GT) begin
              e_open = 1'b1; sc = 1'b1;
            end else if (sp) begin
              phase_next = P_NAME_SL;
            end else if (int'(f) >= PATH_BYTES) begin
              e_err = 1'b1; err_code = ERR_PATH; err_fill = f; phase_next = P_ERR;
            end else begin
              p1 = 1'b1; p1_byte = CH_SLASH; f = f + FILL_W'(1);
              name_len_next = name_len + FILL_W'(1);
              if (c == CH_SLASH) begin
                pend_next = 1'b1;
              end else if (int'(f) >= PATH_BYTES) begin
                e_err = 1'b1; err_code = ERR_PATH; err_fill = f; phase_next = P_ERR;
              end else begin
                p2 = 1'b1; f = f + FILL_W'(1);
                name_len_next = name_len + FILL_W'(2);
              end
            end
          end else if (c == CH_GT) begin
            e_open = 1'b1;
          end else if (sp) begin
            phase_next = P_GAP;
          end else if (c == CH_SLASH) begin
            pend_next = 1'b1;
          end else if (int'(f) >= PATH_BYTES) begin
            e_err = 1'b1; err_code = ERR_PATH; err_fill = f; phase_next = P_ERR;
          end else begin
            p1 = 1'b1; f = f + FILL_W'(1); name_len_next = name_len + FILL_W'(1);
          end
        end
        P_NAME_SL: begin
          if (!sp) begin
            if (c == CH_GT) begin
              e_open = 1'b1; sc = 1'b1;
            end else if (int'(f) >= PATH_BYTES) begin
              e_err = 1'b1; err_code = ERR_PATH; err_fill = f; phase_next = P_ERR;
            end else begin
              p1 = 1'b1; p1_byte = CH_SLASH; f = f + FILL_W'(1);
              name_len_next = name_len + FILL_W'(1);
              phase_next = P_GAP;
              if (c == CH_SLASH) begin
                pend_next = 1'b1; key_at_next = pos; key_len_next = 9'd0;
              end else if (c == CH_EQ) begin
                key_at_next = pos; key_len_next = 9'd0; phase_next = P_VALWAIT;
              end else begin
                key_at_next = pos; key_len_next = 9'd1; phase_next = P_KEY;
              end
            end
          end
        end
        P_GAP: begin
          if (pend) begin
            pend_next = 1'b0;
            if (c == CH_GT) begin
              e_open = 1'b1; sc = 1'b1;
            end else if (sp) begin
              phase_next = P_GAP_SL;
            end else if (c == CH_EQ) begin
              key_len_next = 9'd1; phase_next = P_VALWAIT;
            end else begin
              // key already holds the slash, this byte extends it
              key_len_next = 9'd2; phase_next = P_KEY;
            end
          end else if (!sp) begin
            if (c == CH_GT) begin
              e_open = 1'b1;
            end else if (c == CH_SLASH) begin
              pend_next = 1'b1; key_at_next = pos; key_len_next = 9'd0;
            end else if (c == CH_EQ) begin
              key_at_next = pos; key_len_next = 9'd0; phase_next = P_VALWAIT;
            end else begin
              key_at_next = pos; key_len_next = 9'd1; phase_next = P_KEY;
            end
          end
        end
        P_GAP_SL: begin
          if (!sp) begin
            if (c == CH_GT) begin
              e_open = 1'b1; sc = 1'b1;
            end else if (c == CH_EQ) begin
              key_len_next = 9'd1; phase_next = P_VALWAIT;
            end else begin
              e_err = 1'b1; err_code = ERR_BAD_ATTR; err_fill = f; phase_next = P_ERR;
            end
          end
        end
        P_KEY: begin
          if (c == CH_GT) begin
            e_err = 1'b1; err_code = ERR_BAD_ATTR; err_fill = f; phase_next = P_ERR;
          end else if (sp) begin
            phase_next = P_AFTER_KEY;
          end else if (c == CH_EQ) begin
            phase_next = P_VALWAIT;
          end else begin
            key_len_next = sat_inc9(key_len);
          end
        end
        P_AFTER_KEY: begin
          if (!sp) begin
            if (c == CH_EQ) begin
              phase_next = P_VALWAIT;
            end else begin
              e_err = 1'b1; err_code = ERR_BAD_ATTR; err_fill = f; phase_next = P_ERR;
            end
          end
        end
        P_VALWAIT: begin
          if (!sp) begin
            if (c inside {CH_DQ, CH_SQ}) begin
              quote_next = c; tok_next = pos + 32'd1; phase_next = P_VALUE;
            end else begin
              e_err = 1'b1; err_code = ERR_BAD_ATTR; err_fill = f; phase_next = P_ERR;
            end
          end
        end
        P_VALUE: begin
          if (c == quote) begin
            if (int'(attrs) >= ATTR_LIMIT) begin
              e_err = 1'b1; err_code = ERR_ATTR_LIMIT; err_fill = f; phase_next = P_ERR;
            end else begin
              attrs_next = attrs + ATTR_W'(1);
              e_attr = 1'b1; ev_fill = f; phase_next = P_GAP;
            end
          end else if (c == CH_GT) begin
            e_err = 1'b1; err_code = ERR_BAD_ATTR; err_fill = f; phase_next = P_ERR;
          end
        end
        default: ;
      endcase

      // tag completion: open, and close for a self-closing tag
      if (e_open) begin
        ev_fill = f;
        if (sc) begin
          e_close = 1'b1; do_pop = 1'b1;
        end
        phase_next = P_OUT; cseen_next = 1'b0; cbeg_next = '0; pend_next = 1'b0;
      end

      if (p1) begin
        wr_en = 1'b1; wr_addr = PATH_AW'(fill); wr_data = p1_byte;
      end
      p2_addr_next = PATH_AW'(fill + FILL_W'(1));
      p2_byte_next = c;
      fill_next    = f;

      if (text.end_of_text && phase_next != P_OUT && phase_next != P_ERR) begin
        e_err4 = 1'b1;
      end

      // event assembly in emission order
      if (e_open) begin
        tmp = '0; tmp.kind = EV_OPEN; tmp.name_offset = name_at_next;
        tmp.name_length = len9(name_len_next); tmp.path_length = 9'(ev_fill);
        tmp.attribute_count = 7'(attrs_next);
        q[n[0]] = tmp; n = n + 2'd1;
      end
      if (e_close) begin
        tmp = '0; tmp.kind = EV_CLOSE; tmp.path_length = 9'(ev_fill);
        if (e_close_txt) begin
          tmp.text_offset = cbeg; tmp.text_length = tok - cbeg;
        end
        q[n[0]] = tmp; n = n + 2'd1;
      end
      if (e_attr) begin
        tmp = '0; tmp.kind = EV_ATTR; tmp.name_offset = key_at;
        tmp.name_length = key_len; tmp.text_offset = tok;
        tmp.text_length = pos - tok; tmp.path_length = 9'(ev_fill);
        tmp.attribute_count = 7'(attrs_next);
        q[n[0]] = tmp; n = n + 2'd1;
      end
      if (e_err) begin
        tmp = '0; tmp.kind = EV_ERROR; tmp.name_offset = pos;
        tmp.path_length = 9'(err_fill); tmp.error_code = err_code;
        q[n[0]] = tmp; n = n + 2'd1;
      end
      if (e_err4 && n != 2'd2) begin
        tmp = '0; tmp.kind = EV_ERROR; tmp.name_offset = pos;
        tmp.path_length = 9'(f); tmp.error_code = ERR_UNFINISHED;
        q[n[0]] = tmp; n = n + 2'd1;
      end
      if (n != 2'd0) begin
        q[n[1]].last_in_run = 1'b1;
      end
      ev0_next = q[0];
      ev1_next = q[1];
      cnt_next = n;

      if (text.end_of_text) begin
        // document done: back to the reset state
        pos_next = '0; phase_next = P_OUT; fill_next = '0; cbeg_next = '0;
        cseen_next = 1'b0; tok_next = '0; key_at_next = '0; key_len_next = '0;
        quote_next = '0; attrs_next = '0; pend_next = 1'b0; name_at_next = '0;
        name_len_next = '0;
      end else begin
        pos_next = pos + 32'd1;
        if (p2) begin
          state_next = S_PUSH2;
        end else if (do_pop) begin
          state_next = S_POP_RD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; phase <= P_OUT; fill <= '0; cbeg <= '0; cseen <= 1'b0;
      tok <= '0; key_at <= '0; key_len <= '0; quote <= '0; attrs <= '0;
      pend <= 1'b0; name_at <= '0; name_len <= '0;
      state <= S_IDLE; cnt <= 2'd0;
    end else begin
      pos <= pos_next; phase <= phase_next; fill <= fill_next; cbeg <= cbeg_next;
      cseen <= cseen_next; tok <= tok_next; key_at <= key_at_next;
      key_len <= key_len_next; quote <= quote_next; attrs <= attrs_next;
      pend <= pend_next; name_at <= name_at_next; name_len <= name_len_next;
      state <= state_next; cnt <= cnt_next;
    end
    p2_addr <= p2_addr_next;
    p2_byte <= p2_byte_next;
    ev0     <= ev0_next;
    ev1     <= ev1_next;
  end

  assign events.valid           = (cnt != 2'd0);
  assign events.event_kind      = ev0.kind;
  assign events.name_offset     = ev0.name_offset;
  assign events.name_length     = ev0.name_length;
  assign events.text_offset     = ev0.text_offset;
  assign events.text_length     = ev0.text_length;
  assign events.path_length     = ev0.path_length;
  assign events.attribute_count = ev0.attribute_count;
  assign events.error_code      = ev0.error_code;
  assign events.last_in_run     = ev0.last_in_run;

endmodule
`default_nettype wire

@@ sv/xet_checker.sv @@
// Port-level assertions for the XML event tokenizer, bound to the top level.
// Uses xet_pkg.
`timescale 1ns / 1ps
`default_nettype none
module xet_props
  import xet_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  event_kind,
  input wire logic [31:0] name_offset,
  input wire logic [8:0]  name_length,
  input wire logic [31:0] text_length,
  input wire logic [6:0]  attribute_count,
  input wire logic [2:0]  error_code,
  input wire logic        last_in_run
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("event dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(event_kind) && $stable(name_offset)
                                && $stable(last_in_run))
    else $error("event changed while stalled");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_ERROR |->
      name_length == 9'd0 && text_length == 32'd0 && attribute_count == 7'd0)
    else $error("error event carries tag fields");

  a_close_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == EV_CLOSE |->
      name_offset == 32'd0 && name_length == 9'd0 && attribute_count == 7'd0
      && error_code == ERR_EMPTY)
    else $error("close event carries name fields");

endmodule

bind xml_event_tokenizer xet_props u_xet_props (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (events.valid),
  .out_ready       (events.ready),
  .event_kind      (events.event_kind),
  .name_offset     (events.name_offset),
  .name_length     (events.name_length),
  .text_length     (events.text_length),
  .attribute_count (events.attribute_count),
  .error_code      (events.error_code),
  .last_in_run     (events.last_in_run)
);
`default_nettype wire

@@ bench/xet_checker.sv @@
// Event checker for the XML event tokenizer: watches both channels, predicts
// the events of every accepted byte and compares them in order.
// Depends on xet_pkg, xet_in_if and xet_ev_if.
`timescale 1ns / 1ps
module xet_checker
  import xet_pkg::*;
(
  input  logic clk,
  input  logic rst,
  xet_in_if    mon_in,
  xet_ev_if    mon_ev,
  output int   errors,
  output int   waiting
);

  // parser state
  logic [31:0] pos, cur, cont_at, tok_at, key_at, name_at, name_len;
  logic [8:0]  key_len;
  logic [7:0]  quote, path_mem [PATH_BYTES];
  phase_t      ph;
  int          fill, attrs;
  logic        cont_seen, pslash;

  ev_t byte_evs[$];
  ev_t events_due[$];

  assign waiting = events_due.size();

  function automatic logic sp(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [8:0] sat9(input logic [31:0] v);
    return (v > 32'd256) ? 9'd256 : v[8:0];
  endfunction

  task automatic clear_state();
    pos = 0; ph = P_OUT; fill = 0; cont_at = 0; cont_seen = 0; tok_at = 0;
    key_at = 0; key_len = 0; quote = 0; attrs = 0; pslash = 0;
    name_at = 0; name_len = 0;
  endtask

  task automatic add_ev(input logic [1:0] k, input logic [31:0] noff, input logic [8:0] nlen,
                        input logic [31:0] toff, input logic [31:0] tlen,
                        input logic [2:0] code, input int acnt);
    ev_t e;
    if (byte_evs.size() >= 2) return;
    e.kind = k; e.name_offset = noff; e.name_length = nlen;
    e.text_offset = toff; e.text_length = tlen; e.path_length = 9'(fill);
    e.attribute_count = 7'(acnt); e.error_code = code; e.last_in_run = 1'b0;
    byte_evs.push_back(e);
  endtask

  task automatic raise(input logic [2:0] code);
    add_ev(EV_ERROR, cur, 0, 0, 0, code, 0);
    ph = P_ERR;
  endtask

  function automatic logic push_path(input logic [7:0] c);
    if (fill >= PATH_BYTES) return 1'b0;
    path_mem[fill] = c;
    fill++;
    return 1'b1;
  endfunction

  task automatic walk_back();
    while (fill > 0 && path_mem[fill-1] != CH_SLASH) fill--;
    if (fill > 0) fill--;
  endtask

  task automatic set_key(input logic [31:0] at, input logic [31:0] len);
    key_at = at;
    key_len = sat9(len);
  endtask

  task automatic close_tag();
    ph = P_OUT; cont_seen = 0; cont_at = 0; pslash = 0;
  endtask

  task automatic open_done(input logic self_close);
    add_ev(EV_OPEN, name_at, sat9(name_len), 0, 0, ERR_EMPTY, attrs);
    if (self_close) begin
      add_ev(EV_CLOSE, 0, 0, 0, 0, ERR_EMPTY, 0);
      walk_back();
    end
    close_tag();
  endtask

  task automatic name_byte(input logic [7:0] c);
    if (c == CH_SLASH) pslash = 1;
    else if (!push_path(c)) raise(ERR_PATH);
    else name_len++;
  endtask

  task automatic key_byte(input logic [7:0] c);
    if (c == CH_GT) raise(ERR_BAD_ATTR);
    else if (sp(c)) ph = P_AFTER_KEY;
    else if (c == CH_EQ) ph = P_VALWAIT;
    else set_key(key_at, 32'(key_len) + 1);
  endtask

  task automatic gap_byte(input logic [7:0] c);
    if (sp(c)) return;
    if (c == CH_GT) open_done(0);
    else if (c == CH_SLASH) begin
      pslash = 1; set_key(cur, 0);
    end else if (c == CH_EQ) begin
      set_key(cur, 0); ph = P_VALWAIT;
    end else begin
      set_key(cur, 1); ph = P_KEY;
    end
  endtask

  task automatic predict_byte(input logic [7:0] c, input logic last);
    byte_evs.delete();
    cur = pos;
    case (ph)
      P_OUT: begin
        if (c == CH_LT) begin
          tok_at = cur; ph = P_TAG;
        end else if (!cont_seen && !sp(c)) begin
          cont_at = cur; cont_seen = 1;
        end
      end
      P_TAG: begin
        if (!sp(c)) begin
          if (c == CH_GT) raise(ERR_EMPTY);
          else if (c == CH_SLASH) ph = P_CLOSE;
          else if (c == CH_QUEST) ph = P_SKIP;
          else begin
            attrs = 0; pslash = 0;
            if ((fill > 0 && !push_path(CH_SLASH)) || !push_path(c)) raise(ERR_PATH);
            else begin
              name_at = cur; name_len = 1; ph = P_NAME;
            end
          end
        end
      end
      P_SKIP: if (c == CH_GT) close_tag();
      P_CLOSE: begin
        if (c == CH_GT) begin
          if (cont_seen) add_ev(EV_CLOSE, 0, 0, cont_at, tok_at - cont_at, ERR_EMPTY, 0);
          else add_ev(EV_CLOSE, 0, 0, 0, 0, ERR_EMPTY, 0);
          walk_back();
          close_tag();
        end
      end
      P_NAME: begin
        if (pslash) begin
          pslash = 0;
          if (c == CH_GT) open_done(1);
          else if (sp(c)) ph = P_NAME_SL;
          else if (!push_path(CH_SLASH)) raise(ERR_PATH);
          else begin
            name_len++; name_byte(c);
          end
        end else if (c == CH_GT) open_done(0);
        else if (sp(c)) ph = P_GAP;
        else name_byte(c);
      end
      P_NAME_SL: begin
        if (!sp(c)) begin
          if (c == CH_GT) open_done(1);
          else if (!push_path(CH_SLASH)) raise(ERR_PATH);
          else begin
            name_len++; ph = P_GAP; gap_byte(c);
          end
        end
      end
      P_GAP: begin
        if (pslash) begin
          pslash = 0;
          if (c == CH_GT) open_done(1);
          else if (sp(c)) ph = P_GAP_SL;
          else if (c == CH_EQ) begin
            set_key(key_at, 1); ph = P_VALWAIT;
          end else begin
            set_key(key_at, 1); ph = P_KEY; key_byte(c);
          end
        end else gap_byte(c);
      end
      P_GAP_SL: begin
        if (!sp(c)) begin
          if (c == CH_GT) open_done(1);
          else if (c == CH_EQ) begin
            set_key(key_at, 1); ph = P_VALWAIT;
          end else raise(ERR_BAD_ATTR);
        end
      end
      P_KEY: key_byte(c);
      P_AFTER_KEY: begin
        if (!sp(c)) begin
          if (c == CH_EQ) ph = P_VALWAIT;
          else raise(ERR_BAD_ATTR);
        end
      end
      P_VALWAIT: begin
        if (!sp(c)) begin
          if (c == CH_DQ || c == CH_SQ) begin
            quote = c; tok_at = cur + 1; ph = P_VALUE;
          end else raise(ERR_BAD_ATTR);
        end
      end
      P_VALUE: begin
        if (c == quote) begin
          if (attrs >= ATTR_LIMIT) raise(ERR_ATTR_LIMIT);
          else begin
            attrs++;
            add_ev(EV_ATTR, key_at, key_len, tok_at, cur - tok_at, ERR_EMPTY, attrs);
            ph = P_GAP;
          end
        end else if (c == CH_GT) raise(ERR_BAD_ATTR);
      end
      default: ;
    endcase
    if (last) begin
      if (ph != P_OUT && ph != P_ERR) raise(ERR_UNFINISHED);
      clear_state();
    end else begin
      pos++;
    end
    if (byte_evs.size() > 0) byte_evs[byte_evs.size()-1].last_in_run = 1'b1;
    foreach (byte_evs[i]) events_due.push_back(byte_evs[i]);
  endtask

  task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  task automatic check_event();
    ev_t e;
    if (events_due.size() == 0) begin
      $display("%0t: unexpected event, expected none, got kind %0d", $time,
               mon_ev.event_kind);
      errors++;
      return;
    end
    e = events_due.pop_front();
    check_field("event_kind", e.kind, mon_ev.event_kind);
    check_field("name_offset", e.name_offset, mon_ev.name_offset);
    check_field("name_length", e.name_length, mon_ev.name_length);
    check_field("text_offset", e.text_offset, mon_ev.text_offset);
    check_field("text_length", e.text_length, mon_ev.text_length);
    check_field("path_length", e.path_length, mon_ev.path_length);
    check_field("attribute_count", e.attribute_count, mon_ev.attribute_count);
    check_field("error_code", e.error_code, mon_ev.error_code);
    check_field("last_in_run", e.last_in_run, mon_ev.last_in_run);
  endtask

  initial begin
    errors = 0;
    clear_state();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      events_due.delete();
    end else begin
      if (mon_in.valid && mon_in.ready) predict_byte(mon_in.text_byte, mon_in.end_of_text);
      if (mon_ev.valid && mon_ev.ready) check_event();
    end
  end

endmodule

@@ bench/tb_xml_event_tokenizer.sv @@
// Testbench top for the XML event tokenizer: clock, reset, document stimulus
// with sender and receiver idling, and the verdict. Uses xet_pkg, both
// channel interfaces, the tokenizer and xet_checker.
`timescale 1ns / 1ps
module tb_xml_event_tokenizer;
  import xet_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 1200;  // a pop can walk the whole path store

  logic clk, rst;
  int   errors, waiting, cycles;
  int   send_idle, recv_idle;        // idle percentages of sender and receiver
  logic hold_req, hold_done;         // one long receiver hold-off
  int   hold_left;
  byte  doc[$];                      // document under construction
  int   bytes_sent;

  xet_in_if in_ch ();
  xet_ev_if ev_ch ();

  xml_event_tokenizer u_top (.clk(clk), .rst(rst), .text(in_ch), .events(ev_ch));

  xet_checker u_chk (.clk(clk), .rst(rst), .mon_in(in_ch), .mon_ev(ev_ch),
                     .errors(errors), .waiting(waiting));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog; normal runs end far below this.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[xml_event_tokenizer] ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a single long hold-off once requested so the
  // block backs up and stops taking bytes.
  initial begin
    ev_ch.ready = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        ev_ch.ready = 0;
      end else begin
        ev_ch.ready = ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Offer one byte; returns at the falling edge after it was taken.
  task automatic send_byte(input byte b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 0;
      @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.text_byte = b;
    in_ch.end_of_text = last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_doc();
    foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1);
    in_ch.valid = 0;
    doc.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
  endtask

  task automatic add_rep(input byte b, input int n);
    repeat (n) doc.push_back(b);
  endtask

  task automatic add_space();
    byte sp_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    repeat ($urandom_range(1, 2)) doc.push_back(sp_set[$urandom_range(5)]);
  endtask

  task automatic add_name(input int max_len);
    int n;
    n = $urandom_range(1, max_len);
    for (int i = 0; i < n; i++) doc.push_back(byte'($urandom_range(97, 122)));
  endtask

  // Element text: letters, spaces and arbitrary bytes, never a '<'.
  task automatic add_text();
    byte b;
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(3))
        0: add_space();
        1: begin
          b = byte'($urandom_range(255));
          doc.push_back(b == CH_LT ? 8'hBC : b);
        end
        default: doc.push_back(byte'($urandom_range(65, 90)));
      endcase
    end
  endtask

  task automatic add_attrs();
    int n;
    byte q;
    n = ($urandom_range(99) == 0) ? 66 : $urandom_range(0, 3);
    repeat (n) begin
      q = $urandom_range(1) ? CH_DQ : CH_SQ;
      add_space();
      add_name(5);
      if ($urandom_range(3) == 0) add_space();
      doc.push_back(CH_EQ);
      if ($urandom_range(3) == 0) add_space();
      doc.push_back(q);
      add_text();
      doc.push_back(q);
    end
  endtask

  task automatic add_elem(input int depth);
    int mark;
    doc.push_back(CH_LT);
    mark = doc.size();
    add_name(6);
    add_attrs();
    if ($urandom_range(3) == 0) begin
      if ($urandom_range(1)) add_space();
      add_str("/>");
    end else begin
      doc.push_back(CH_GT);
      add_text();
      if (depth < 5)
        repeat ($urandom_range(0, 3)) begin
          add_elem(depth + 1);
          add_text();
        end
      add_str("</");
      add_name(6);
      doc.push_back(CH_GT);
    end
  endtask

  // Mostly well-formed documents; some get corrupted or cut short.
  task automatic random_doc();
    int k;
    if ($urandom_range(2) == 0) add_str("<?xml version=\"1.0\"?>");
    add_space();
    add_elem(0);
    add_space();
    k = $urandom_range(9);
    if (k == 0) doc[$urandom_range(doc.size() - 1)] = byte'($urandom_range(255));
    else if (k == 1) doc = doc[0:$urandom_range(doc.size() - 1)];
    else if (k == 2) begin
      doc.delete();
      repeat ($urandom_range(1, 30)) doc.push_back(byte'($urandom_range(255)));
    end
    send_doc();
  endtask

  task automatic directed_docs();
    add_str("<a>hi there </a>"); send_doc();
    add_str("<a/>"); send_doc();
    add_str("<a / ><b x/ ='v'/></b>"); send_doc();
    add_str("<? skip ?><r k='v' q=\"w\">t<c/></r>"); send_doc();
    add_str("<>"); send_doc();
    add_str("<a b>"); send_doc();
    add_str("<a b=c>"); send_doc();
    add_str("<a k='v>'"); send_doc();
    add_str("<a b =x"); send_doc();
    add_str("<a / x>"); send_doc();
    add_str("<a/b c/d='1'></a/b>"); send_doc();
    add_str("<a"); send_doc();
    add_str("\xff"); send_doc();
    // longest name that fits, then one that overflows the path
    doc.push_back(CH_LT); add_rep("n", 256); add_str("></x>"); send_doc();
    doc.push_back(CH_LT); add_rep("n", 260); add_str(">"); send_doc();
    // key length saturates
    add_str("<k "); add_rep("k", 300); add_str("='v'></k>"); send_doc();
    // attribute limit: the 65th value raises an error
    add_str("<m");
    repeat (65) add_str(" a='1'");
    add_str(">"); send_doc();
    // deep nesting overflows the path store
    repeat (100) add_str("<ab>");
    send_doc();
  endtask

  initial begin
    rst = 1;
    hold_req = 0;
    in_ch.valid = 0;
    in_ch.text_byte = 0;
    in_ch.end_of_text = 0;
    bytes_sent = 0;
    send_idle = 18;
    recv_idle = 51;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    directed_docs();
    // three idling phases of random documents
    for (int ph_i = 0; ph_i < 3; ph_i++) begin
      send_idle = (ph_i == 0) ? 18 : (ph_i == 1) ? 51 : 0;
      recv_idle = (ph_i == 0) ? 51 : (ph_i == 1) ? 18 : 0;
      if (ph_i == 1) hold_req = 1;
      bytes_sent = 0;
      while (bytes_sent < 100) random_doc();
    end

    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("[xml_event_tokenizer] OK");
    end else begin
      $display("[xml_event_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
